// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/dsfm_pkg.sv
// ---------------------------------------------------------------------------
// dsfm_pkg
// Types, codes and the function-write rule of the switch function mapper.
// ---------------------------------------------------------------------------
package dsfm_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int PIN_W        = 4;
    localparam int HIST_W       = 3;
    localparam int CODE_W       = 4;
    localparam int MODE_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 4;

    localparam logic [HIST_W-1:0] HIST_ALL_ON  = 3'b111;
    localparam logic [HIST_W-1:0] HIST_ALL_OFF = 3'b000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CH0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CH1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CH2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CH3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd4;

    // function codes
    localparam logic [CODE_W-1:0] FN_NONE    = 4'd0;
    localparam logic [CODE_W-1:0] FN_LEFT    = 4'd1;
    localparam logic [CODE_W-1:0] FN_RIGHT   = 4'd2;
    localparam logic [CODE_W-1:0] FN_CENTER  = 4'd3;
    localparam logic [CODE_W-1:0] FN_MANUAL  = 4'd4;
    localparam logic [CODE_W-1:0] FN_AUTO    = 4'd5;
    localparam logic [CODE_W-1:0] FN_OPREADY = 4'd6;
    localparam logic [CODE_W-1:0] FN_RETRACT = 4'd7;
    localparam logic [CODE_W-1:0] FN_EXTEND  = 4'd8;
    localparam logic [CODE_W-1:0] FN_EPC1    = 4'd9;
    localparam logic [CODE_W-1:0] FN_EPC2    = 4'd10;

    // EPC functions act only in sensor modes up to this one
    localparam logic [MODE_W-1:0] MODE_EPC_MAX = 3'd1;

    // function values
    localparam logic [1:0] PUSH_IDLE   = 2'd0;
    localparam logic [1:0] PUSH_RIGHT  = 2'd1;
    localparam logic [1:0] PUSH_LEFT   = 2'd2;
    localparam logic [2:0] CENTER_OFF  = 3'd0;
    localparam logic [2:0] CENTER_ON   = 3'd5;
    localparam logic [2:0] SEL_LOW     = 3'd2;
    localparam logic [2:0] SEL_HIGH    = 3'd4;

    typedef struct packed {
        logic       level;
        logic       change;
    } chan_stat_t;

    typedef struct packed {
        logic [1:0] left_push;
        logic [1:0] right_push;
        logic [2:0] center_return;
        logic [2:0] manual_select;
        logic [2:0] auto_select;
        logic       operation_ready;
        logic       retract_limit;
        logic       extend_limit;
        logic       epc1_switch;
        logic       epc2_switch;
    } fv_t;

    // apply one channel's level change to the function values
    function automatic fv_t apply_fn(fv_t fv, logic [CODE_W-1:0] code, logic level,
                                     logic epc_en);
        fv_t r;
        r = fv;
        unique case (code)
            FN_LEFT:
            begin
                r.left_push  = level ? PUSH_LEFT : PUSH_IDLE;
                r.right_push = level ? PUSH_LEFT : PUSH_IDLE;
            end
            FN_RIGHT:
            begin
                r.left_push  = level ? PUSH_RIGHT : PUSH_IDLE;
                r.right_push = level ? PUSH_RIGHT : PUSH_IDLE;
            end
            FN_CENTER:  r.center_return   = level ? CENTER_ON : CENTER_OFF;
            FN_MANUAL:  r.manual_select   = level ? SEL_HIGH : SEL_LOW;
            FN_AUTO:    r.auto_select     = level ? SEL_LOW : SEL_HIGH;
            FN_OPREADY: r.operation_ready = level;
            FN_RETRACT: r.retract_limit   = level;
            FN_EXTEND:  r.extend_limit    = level;
            FN_EPC1:
            begin
                if (epc_en)
                    r.epc1_switch = level;
            end
            FN_EPC2:
            begin
                if (epc_en)
                    r.epc2_switch = level;
            end
            default: ; // none and unused codes write nothing
        endcase
        return r;
    endfunction

endpackage

// File: rtl/dsfm_chan.sv
// ---------------------------------------------------------------------------
// dsfm_chan
// One switch channel: 3-sample history and debounced level.
// ---------------------------------------------------------------------------
module dsfm_chan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                pressed,
    output dsfm_pkg::chan_stat_t stat
);
    import dsfm_pkg::*;

    logic [HIST_W-1:0] hist_reg;
    logic [HIST_W-1:0] hist_next;
    logic              level_reg;
    logic              level_next;

    // shift in the new sample; full agreement sets or clears the level
    always_comb
    begin
        hist_next = {hist_reg[HIST_W-2:0], pressed};
        priority if (hist_next == HIST_ALL_ON)
            level_next = 1'b1;
        else if (hist_next == HIST_ALL_OFF)
            level_next = 1'b0;
        else
            level_next = level_reg;
    end

    assign stat.level  = level_next;
    assign stat.change = level_next != level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            level_reg <= 1'b0;
        end
        else if (step)
        begin
            hist_reg  <= hist_next;
            level_reg <= level_next;
        end
    end

endmodule

// File: rtl/dsfm_map.sv
// ---------------------------------------------------------------------------
// dsfm_map
// Function value registers, rewritten by channel changes in channel order.
// ---------------------------------------------------------------------------
module dsfm_map #(
    parameter int CHANNELS = dsfm_pkg::CHANNELS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          step,
    input  dsfm_pkg::chan_stat_t [CHANNELS-1:0]           stat,
    input  logic [CHANNELS-1:0][dsfm_pkg::CODE_W-1:0]     codes,
    input  logic                                          epc_en,
    output dsfm_pkg::fv_t                                 fv
);
    import dsfm_pkg::*;

    fv_t fv_reg;
    fv_t fv_next;

    // later channels overwrite earlier ones
    always_comb
    begin
        fv_next = fv_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (stat[i].change)
                fv_next = apply_fn(fv_next, codes[i], stat[i].level, epc_en);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else if (step)
            fv_reg <= fv_next;
    end

    assign fv = fv_reg;

endmodule

// File: rtl/debounced_switch_function_mapper_core.sv
// ---------------------------------------------------------------------------
// debounced_switch_function_mapper_core
// Debounces four active-low switch pins and maps level changes to functions.
// ---------------------------------------------------------------------------
// Takes one beat per clock while out_ready does not stall the result. Each
// pin_levels beat is one sampling tick: it lands in an input register, then
// one combinational pass over the channels updates the debounce histories and
// the function value registers (the result beat) once the result slot is free;
// the single pass through the channel chain sets the one-beat-per-cycle rate.
// The input side keeps accepting while a result waits, until both the input
// register and the result are held. Configuration writes take effect at once
// and are meant to be done while the block is idle.
`include "assert_macros.svh"

module debounced_switch_function_mapper_core #(
    parameter int CHANNELS = dsfm_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [dsfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dsfm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dsfm_pkg::PIN_W-1:0]          pin_levels,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          left_push,
    output logic [1:0]                          right_push,
    output logic [2:0]                          center_return,
    output logic [2:0]                          manual_select,
    output logic [2:0]                          auto_select,
    output logic                                operation_ready,
    output logic                                retract_limit,
    output logic                                extend_limit,
    output logic                                epc1_switch,
    output logic                                epc2_switch
);
    import dsfm_pkg::*;

    localparam int CFG_CH = 4;

    logic [CFG_CH-1:0][CODE_W-1:0]  fn_reg;
    logic [MODE_W-1:0]              mode_reg;
    logic                           in_valid_reg;
    logic [PIN_W-1:0]               pins_reg;
    logic                           out_valid_reg;
    logic                           advance;
    logic                           epc_en;
    chan_stat_t [CHANNELS-1:0]      stat;
    logic [CHANNELS-1:0][CODE_W-1:0] codes;
    fv_t                            fv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fn_reg   <= '0;
            mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CH0:  fn_reg[0] <= cfg_data;
                REG_CH1:  fn_reg[1] <= cfg_data;
                REG_CH2:  fn_reg[2] <= cfg_data;
                REG_CH3:  fn_reg[3] <= cfg_data;
                REG_MODE: mode_reg  <= cfg_data[MODE_W-1:0];
                default:  ;
            endcase
        end
    end

    assign epc_en = mode_reg <= MODE_EPC_MAX;

    // handshake: process when a tick is held and the result slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            pins_reg <= pin_levels;
    end

    // channel debouncers
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_chan
        assign codes[g] = fn_reg[g];

        dsfm_chan u_chan (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (advance),
            .pressed (!pins_reg[g]),
            .stat    (stat[g])
        );
    end

    // function value registers
    dsfm_map #(
        .CHANNELS (CHANNELS)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .stat   (stat),
        .codes  (codes),
        .epc_en (epc_en),
        .fv     (fv)
    );

    assign left_push       = fv.left_push;
    assign right_push      = fv.right_push;
    assign center_return   = fv.center_return;
    assign manual_select   = fv.manual_select;
    assign auto_select     = fv.auto_select;
    assign operation_ready = fv.operation_ready;
    assign retract_limit   = fv.retract_limit;
    assign extend_limit    = fv.extend_limit;
    assign epc1_switch     = fv.epc1_switch;
    assign epc2_switch     = fv.epc2_switch;

    // checks
    `ASSERT_IMP(a_full_stall, clk, rst_n, in_valid_reg && out_valid_reg && !out_ready, !in_ready)
    `ASSERT_NXT(a_hold_values, clk, rst_n, !advance, $stable(fv))
    `ASSERT_NXT(a_result_after_tick, clk, rst_n, advance, out_valid)

endmodule
